### rtl/srsp_pkg.sv
// Shared types, constants and codes for the stripe read segment planner.
package srsp_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

    localparam int HASH_W     = 64;
    localparam int OFF_W      = 48;
    localparam int LEN_W      = 32;
    localparam int UNIT_W     = 31;
    localparam int DRV_CNT_W  = 7;
    localparam int DRV_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int ALU_W      = 64;
    localparam int ACC_W      = 48;
    localparam int STEP_W     = 7;

    localparam logic [UNIT_W-1:0]    UNIT_RESET   = UNIT_W'(65536);
    localparam logic [UNIT_W-1:0]    UNIT_MAX     = UNIT_W'(1073741824);
    localparam logic [DRV_CNT_W-1:0] DRIVES_RESET = DRV_CNT_W'(1);
    localparam logic [DRV_CNT_W-1:0] DRIVES_MAX   = DRV_CNT_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_UNIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_COUNT = CFG_IDX_W'(1);

    typedef struct packed {
        logic [HASH_W-1:0] obj_hash;
        logic [OFF_W-1:0]  logical_offset;
        logic [LEN_W-1:0]  read_length;
    } t_req;

    typedef struct packed {
        logic [DRV_W-1:0]  drive_index;
        logic [OFF_W-1:0]  file_offset;
        logic [UNIT_W-1:0] segment_length;
        logic              last_segment;
    } t_seg;

    typedef enum logic [1:0] {
        OP_DIV = 2'b01,
        OP_MUL = 2'b10
    } t_alu_op;

    typedef struct packed {
        logic              start;
        t_alu_op           op;
        logic [ALU_W-1:0]  a;
        logic [ACC_W-1:0]  opnd;
        logic [STEP_W-1:0] steps;
    } t_alu_cmd;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] q;
        logic [ACC_W-1:0] acc;
    } t_alu_rsp;

endpackage

### rtl/stripe_read_segment_planner.sv
// Top level: request sequencer, segment stepping and output register.
//
//   beat        valid        stall / ready   payload
//   request     i_in_valid   o_in_stall      i_in_data   (srsp_pkg::t_req)
//   segment     o_out_valid  i_out_stall     o_out_data  (srsp_pkg::t_seg)
//   config      i_cfg_valid  o_cfg_ready     i_cfg_index, i_cfg_data
//
// A request runs four serial passes on the shared unit: offset / unit, chunk / drives,
// row * unit and (hash + chunk) / drives. Segments then leave at one per cycle while
// the output is not stalled, up to 64; a request whose range crosses the top of the
// 48-bit offset space repeats the four passes once at the wrap.
// A zero-length request is accepted while idle and produces nothing.
// Reset is synchronous; no clearing pass. A stalled output holds the sequencer.
module stripe_read_segment_planner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  srsp_pkg::t_req                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output srsp_pkg::t_seg                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV_U = 6'b000010,
        S_DIV_D = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV_H = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    localparam int PAD_OFF  = srsp_pkg::ALU_W - srsp_pkg::OFF_W;
    localparam int PAD_UNIT = srsp_pkg::ALU_W - srsp_pkg::UNIT_W;

    logic [srsp_pkg::UNIT_W-1:0]    unit;
    logic [srsp_pkg::DRV_CNT_W-1:0] drives;

    srsp_pkg::t_alu_cmd alu_cmd;
    srsp_pkg::t_alu_rsp alu_rsp;

    t_state                          r_state,   n_state;
    logic [srsp_pkg::HASH_W-1:0]     r_hash,    n_hash;
    logic [srsp_pkg::HASH_W-1:0]     r_hsum,    n_hsum;
    logic [srsp_pkg::OFF_W-1:0]      r_cur,     n_cur;
    logic [srsp_pkg::LEN_W-1:0]      r_remain,  n_remain;
    logic [srsp_pkg::UNIT_W-1:0]     r_intra,   n_intra;
    logic [srsp_pkg::DRV_W-1:0]      r_cmod,    n_cmod;
    logic [srsp_pkg::DRV_W-1:0]      r_drv,     n_drv;
    logic [srsp_pkg::OFF_W-1:0]      r_base,    n_base;
    logic [srsp_pkg::SEG_CNT_W-1:0]  r_seg_cnt, n_seg_cnt;
    logic                            r_out_valid;
    srsp_pkg::t_seg                  r_out;

    logic [srsp_pkg::UNIT_W-1:0]     room;
    logic [srsp_pkg::UNIT_W-1:0]     seg_len;
    logic                            seg_last;
    logic [srsp_pkg::OFF_W:0]        cur_sum;
    logic [srsp_pkg::DRV_CNT_W-1:0]  cmod_inc;
    logic [srsp_pkg::DRV_CNT_W-1:0]  drv_inc;
    logic                            out_free;
    logic                            out_load;
    srsp_pkg::t_seg                  seg;

    srsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_unit      (unit),
        .o_drives    (drives)
    );

    srsp_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .o_rsp   (alu_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        room     = unit - r_intra;
        if ({1'b0, room} > r_remain) begin
            seg_len = r_remain[srsp_pkg::UNIT_W-1:0];
        end else begin
            seg_len = room;
        end
        seg_last = (r_remain <= {1'b0, room})
                 || (r_seg_cnt == srsp_pkg::SEG_CNT_W'(srsp_pkg::MAX_SEGMENTS - 1));
        cur_sum  = {1'b0, r_cur} + (srsp_pkg::OFF_W + 1)'(seg_len);
        cmod_inc = {1'b0, r_cmod} + srsp_pkg::DRV_CNT_W'(1);
        drv_inc  = {1'b0, r_drv} + srsp_pkg::DRV_CNT_W'(1);

        seg.drive_index    = r_drv;
        seg.file_offset    = r_base + srsp_pkg::OFF_W'(r_intra);
        seg.segment_length = seg_len;
        seg.last_segment   = seg_last;
        out_load           = (r_state == S_EMIT) && out_free;
    end

    always_comb begin
        n_state   = r_state;
        n_hash    = r_hash;
        n_hsum    = r_hsum;
        n_cur     = r_cur;
        n_remain  = r_remain;
        n_intra   = r_intra;
        n_cmod    = r_cmod;
        n_drv     = r_drv;
        n_base    = r_base;
        n_seg_cnt = r_seg_cnt;
        alu_cmd   = '{start: 1'b0, op: srsp_pkg::OP_DIV, a: '0, opnd: '0, steps: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_data.read_length != '0) begin
                    n_hash        = i_in_data.obj_hash;
                    n_cur         = i_in_data.logical_offset;
                    n_remain      = i_in_data.read_length;
                    n_seg_cnt     = '0;
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = srsp_pkg::OP_DIV;
                    alu_cmd.a     = {i_in_data.logical_offset, PAD_OFF'(0)};
                    alu_cmd.opnd  = srsp_pkg::ACC_W'(unit);
                    alu_cmd.steps = srsp_pkg::STEP_W'(srsp_pkg::OFF_W);
                    n_state       = S_DIV_U;
                end
            end
            S_DIV_U: begin
                if (alu_rsp.done) begin
                    n_intra       = alu_rsp.acc[srsp_pkg::UNIT_W-1:0];
                    n_hsum        = r_hash
                                  + srsp_pkg::HASH_W'(alu_rsp.q[srsp_pkg::OFF_W-1:0]);
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = srsp_pkg::OP_DIV;
                    alu_cmd.a     = {alu_rsp.q[srsp_pkg::OFF_W-1:0], PAD_OFF'(0)};
                    alu_cmd.opnd  = srsp_pkg::ACC_W'(drives);
                    alu_cmd.steps = srsp_pkg::STEP_W'(srsp_pkg::OFF_W);
                    n_state       = S_DIV_D;
                end
            end
            S_DIV_D: begin
                if (alu_rsp.done) begin
                    n_cmod        = alu_rsp.acc[srsp_pkg::DRV_W-1:0];
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = srsp_pkg::OP_MUL;
                    alu_cmd.a     = {unit, PAD_UNIT'(0)};
                    alu_cmd.opnd  = alu_rsp.q[srsp_pkg::OFF_W-1:0];
                    alu_cmd.steps = srsp_pkg::STEP_W'(srsp_pkg::UNIT_W);
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                if (alu_rsp.done) begin
                    n_base        = alu_rsp.acc;
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = srsp_pkg::OP_DIV;
                    alu_cmd.a     = r_hsum;
                    alu_cmd.opnd  = srsp_pkg::ACC_W'(drives);
                    alu_cmd.steps = srsp_pkg::STEP_W'(srsp_pkg::HASH_W);
                    n_state       = S_DIV_H;
                end
            end
            S_DIV_H: begin
                if (alu_rsp.done) begin
                    n_drv   = alu_rsp.acc[srsp_pkg::DRV_W-1:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_remain  = r_remain - srsp_pkg::LEN_W'(seg_len);
                    n_seg_cnt = r_seg_cnt + srsp_pkg::SEG_CNT_W'(1);
                    n_cur     = cur_sum[srsp_pkg::OFF_W-1:0];
                    if (seg_last) begin
                        n_state = S_IDLE;
                    end else if (cur_sum[srsp_pkg::OFF_W]) begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = srsp_pkg::OP_DIV;
                        alu_cmd.a     = {cur_sum[srsp_pkg::OFF_W-1:0], PAD_OFF'(0)};
                        alu_cmd.opnd  = srsp_pkg::ACC_W'(unit);
                        alu_cmd.steps = srsp_pkg::STEP_W'(srsp_pkg::OFF_W);
                        n_state       = S_DIV_U;
                    end else begin
                        n_intra = '0;
                        n_hsum  = r_hsum + srsp_pkg::HASH_W'(1);
                        if (cmod_inc == drives) begin
                            n_cmod = '0;
                            n_base = r_base + srsp_pkg::OFF_W'(unit);
                        end else begin
                            n_cmod = cmod_inc[srsp_pkg::DRV_W-1:0];
                        end
                        if (r_hsum == '1 || drv_inc == drives) begin
                            n_drv = '0;
                        end else begin
                            n_drv = drv_inc[srsp_pkg::DRV_W-1:0];
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seg_cnt   <= n_seg_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash   <= n_hash;
        r_hsum   <= n_hsum;
        r_cur    <= n_cur;
        r_remain <= n_remain;
        r_intra  <= n_intra;
        r_cmod   <= n_cmod;
        r_drv    <= n_drv;
        r_base   <= n_base;
        if (out_load) begin
            r_out <= seg;
        end
    end

    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !alu_rsp.done)
        else $error("shared unit finished while sequencer idle");

    a_seg_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_seg_cnt < srsp_pkg::SEG_CNT_W'(srsp_pkg::MAX_SEGMENTS))
        else $error("segment count beyond limit");

    a_last_ends_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && seg.last_segment |=> r_state == S_IDLE && o_out_valid)
        else $error("request not closed after last segment");

    a_seg_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> seg.segment_length != '0 && seg.segment_length <= unit)
        else $error("segment length out of range");

endmodule

### rtl/srsp_cfg.sv
// Configuration registers with clamping to the legal stripe unit and drive count.
module srsp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic [srsp_pkg::UNIT_W-1:0]     o_unit,
    output logic [srsp_pkg::DRV_CNT_W-1:0]  o_drives
);

    logic [srsp_pkg::UNIT_W-1:0]    r_unit;
    logic [srsp_pkg::DRV_CNT_W-1:0] r_drives;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit   <= srsp_pkg::UNIT_RESET;
            r_drives <= srsp_pkg::DRIVES_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                srsp_pkg::REG_STRIPE_UNIT: r_unit   <= i_cfg_data[srsp_pkg::UNIT_W-1:0];
                srsp_pkg::REG_DRIVE_COUNT: r_drives <= i_cfg_data[srsp_pkg::DRV_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_unit == '0) begin
            o_unit = srsp_pkg::UNIT_W'(1);
        end else if (r_unit > srsp_pkg::UNIT_MAX) begin
            o_unit = srsp_pkg::UNIT_MAX;
        end else begin
            o_unit = r_unit;
        end
        if (r_drives == '0) begin
            o_drives = srsp_pkg::DRV_CNT_W'(1);
        end else if (r_drives > srsp_pkg::DRIVES_MAX) begin
            o_drives = srsp_pkg::DRIVES_MAX;
        end else begin
            o_drives = r_drives;
        end
    end

endmodule

### rtl/srsp_iter_unit.sv
// Shared bit-serial unit: restoring divide and shift-add multiply on one adder.
module srsp_iter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srsp_pkg::t_alu_cmd i_cmd,
    output srsp_pkg::t_alu_rsp o_rsp
);

    logic [srsp_pkg::ALU_W-1:0]  r_q;
    logic [srsp_pkg::ACC_W-1:0]  r_acc;
    logic [srsp_pkg::ACC_W-1:0]  r_opnd;
    logic [srsp_pkg::STEP_W-1:0] r_cnt;
    logic                        r_done;
    srsp_pkg::t_alu_op           r_op;

    logic [srsp_pkg::UNIT_W:0]   div_t;
    logic [srsp_pkg::ACC_W-1:0]  add_x;
    logic [srsp_pkg::ACC_W-1:0]  add_y;
    logic                        add_cin;
    logic [srsp_pkg::ACC_W-1:0]  add_sum;
    logic                        div_ge;
    logic [srsp_pkg::ACC_W-1:0]  n_acc;

    always_comb begin
        div_t   = {r_acc[srsp_pkg::UNIT_W-1:0], r_q[srsp_pkg::ALU_W-1]};
        div_ge  = 1'b0;
        unique case (r_op)
            srsp_pkg::OP_DIV: begin
                add_x   = srsp_pkg::ACC_W'(div_t);
                add_y   = ~srsp_pkg::ACC_W'(r_opnd[srsp_pkg::UNIT_W-1:0]);
                add_cin = 1'b1;
            end
            srsp_pkg::OP_MUL: begin
                add_x   = {r_acc[srsp_pkg::ACC_W-2:0], 1'b0};
                add_y   = r_q[srsp_pkg::ALU_W-1] ? r_opnd : '0;
                add_cin = 1'b0;
            end
            default: begin
                add_x   = '0;
                add_y   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = add_x + add_y + srsp_pkg::ACC_W'(add_cin);
        if (r_op == srsp_pkg::OP_DIV) begin
            div_ge = !add_sum[srsp_pkg::ACC_W-1];
            n_acc  = div_ge ? srsp_pkg::ACC_W'(add_sum[srsp_pkg::UNIT_W-1:0])
                            : srsp_pkg::ACC_W'(div_t[srsp_pkg::UNIT_W-1:0]);
        end else begin
            n_acc  = add_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            r_op   <= srsp_pkg::OP_DIV;
        end else if (i_cmd.start) begin
            r_cnt  <= i_cmd.steps;
            r_done <= 1'b0;
            r_op   <= i_cmd.op;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - srsp_pkg::STEP_W'(1);
            r_done <= (r_cnt == srsp_pkg::STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_q    <= i_cmd.a;
            r_acc  <= '0;
            r_opnd <= i_cmd.opnd;
        end else if (r_cnt != '0) begin
            r_q    <= {r_q[srsp_pkg::ALU_W-2:0], div_ge};
            r_acc  <= n_acc;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.acc  = r_acc;

endmodule

### dv/srsp_segment_checker.sv
`timescale 1ns / 100ps
// Segment checker: watches the request, segment and config channels and scores segments.
module srsp_segment_checker
    import srsp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_req                   i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_seg                   i_out_data,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [63:0] OFF_MASK = 64'hFFFF_FFFF_FFFF;

    logic [UNIT_W-1:0]    unit_reg   = UNIT_RESET;
    logic [DRV_CNT_W-1:0] drives_reg = DRIVES_RESET;
    t_seg                 planned_segs[$];
    int                   fails      = 0;
    int                   waiting    = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic void plan_request(input t_req req);
        logic [63:0] unit_eff;
        logic [63:0] drives_eff;
        logic [63:0] cur;
        logic [63:0] remaining;
        logic [63:0] chunk;
        logic [63:0] intra;
        logic [63:0] room;
        logic [63:0] seg_len;
        logic [63:0] row;
        logic [63:0] drive_sum;
        t_seg        seg;
        int          n;
        unit_eff   = (unit_reg == '0) ? 64'd1 :
                     (unit_reg > UNIT_MAX) ? 64'(UNIT_MAX) : 64'(unit_reg);
        drives_eff = (drives_reg == '0) ? 64'd1 :
                     (drives_reg > DRIVES_MAX) ? 64'(DRIVES_MAX) : 64'(drives_reg);
        cur        = 64'(req.logical_offset);
        remaining  = 64'(req.read_length);
        n          = 0;
        while (remaining != 0 && n < MAX_SEGMENTS) begin
            chunk     = cur / unit_eff;
            intra     = cur % unit_eff;
            room      = unit_eff - intra;
            seg_len   = (remaining < room) ? remaining : room;
            row       = chunk / drives_eff;
            drive_sum = req.obj_hash + chunk;
            seg.drive_index    = DRV_W'(drive_sum % drives_eff);
            seg.file_offset    = OFF_W'(row * unit_eff + intra);
            seg.segment_length = UNIT_W'(seg_len);
            seg.last_segment   = (remaining == seg_len) || (n == MAX_SEGMENTS - 1);
            planned_segs.push_back(seg);
            n++;
            cur       = (cur + seg_len) & OFF_MASK;
            remaining = remaining - seg_len;
        end
    endfunction

    always @(posedge i_clk) begin
        t_seg want;
        if (!i_rst_n) begin
            unit_reg   = UNIT_RESET;
            drives_reg = DRIVES_RESET;
            planned_segs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_STRIPE_UNIT: unit_reg   = i_cfg_data[UNIT_W-1:0];
                    REG_DRIVE_COUNT: drives_reg = i_cfg_data[DRV_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                plan_request(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (planned_segs.size() == 0) begin
                    $error("segment beat with nothing expected: drive %0d offset 0x%0h len %0d",
                           i_out_data.drive_index, i_out_data.file_offset,
                           i_out_data.segment_length);
                    fails++;
                end else begin
                    want = planned_segs.pop_front();
                    if (i_out_data.drive_index !== want.drive_index) begin
                        $error("drive_index: expected %0d, actual %0d",
                               want.drive_index, i_out_data.drive_index);
                        fails++;
                    end
                    if (i_out_data.file_offset !== want.file_offset) begin
                        $error("file_offset: expected 0x%0h, actual 0x%0h",
                               want.file_offset, i_out_data.file_offset);
                        fails++;
                    end
                    if (i_out_data.segment_length !== want.segment_length) begin
                        $error("segment_length: expected %0d, actual %0d",
                               want.segment_length, i_out_data.segment_length);
                        fails++;
                    end
                    if (i_out_data.last_segment !== want.last_segment) begin
                        $error("last_segment: expected %0b, actual %0b",
                               want.last_segment, i_out_data.last_segment);
                        fails++;
                    end
                end
            end
        end
        waiting = planned_segs.size();
    end

endmodule

### dv/tb_stripe_read_segment_planner.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and config stimulus, output back-pressure and verdict.
module tb_stripe_read_segment_planner;
    import srsp_pkg::*;

    localparam int          SETTLE_CYCLES    = 600;
    localparam int          STALL_LIMIT      = 20000;
    localparam int          HOLD_OFF_CYCLES  = 1500;
    localparam int          ITEMS_PER_PHASE  = 65;
    localparam int          RANDOM_PHASES    = 6;
    localparam int          PRESSURE_PHASE   = 3;
    localparam logic [47:0] OFF_TOP          = 48'hFFFF_FFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_seg                  o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int          fail_total;
    int          pending;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          hold_off_len = 0;
    int          quiet_cycles = 0;
    logic [63:0] unit_now     = 64'(UNIT_RESET);

    stripe_read_segment_planner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    srsp_segment_checker u_segment_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_total),
        .o_pending    (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_len - 1) @(negedge i_clk);
                hold_off_len = 0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no beat for %0d cycles, %0d segments outstanding", quiet_cycles, pending);
            $display("** stripe_read_segment_planner: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input logic [63:0] hash, input logic [47:0] offset,
                            input logic [31:0] length);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{obj_hash: hash, logical_offset: offset, read_length: length};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [31:0] unit_word, input logic [31:0] drive_word);
        logic [UNIT_W-1:0] u;
        u = unit_word[UNIT_W-1:0];
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if ($urandom_range(0, 2) == 0)
            write_cfg(($urandom_range(0, 1) != 0) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
        write_cfg(REG_STRIPE_UNIT, unit_word);
        write_cfg(REG_DRIVE_COUNT, drive_word);
        i_cfg_valid <= 1'b0;
        unit_now = (u == '0) ? 64'd1 : (u > UNIT_MAX) ? 64'(UNIT_MAX) : 64'(u);
    endtask

    initial begin
        logic [63:0]          wide;
        logic [63:0]          hash;
        logic [47:0]          offset;
        logic [63:0]          span;
        logic [63:0]          span_len;
        logic [UNIT_W-1:0]    unit_field;
        logic [DRV_CNT_W-1:0] drive_field;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(64'd0, 48'd0, 32'd0);
        send_req(64'd0, 48'd0, 32'd1);
        send_req('1, OFF_TOP, '1);
        send_req(64'd5, 48'd65535, 32'd2);

        set_geometry(32'd1, 32'd64);
        send_req('1, 48'd0, 32'd64);
        send_req({$urandom, $urandom}, 48'd10, 32'd65);
        send_req(64'd0, OFF_TOP - 48'd2, 32'd6);

        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(64'hFFFF_FFFF_FFFF_FFC0, OFF_TOP, '1);
        send_req(64'd3, 48'd0, 32'h4000_0000);

        set_geometry(32'h8000_0000, 32'hFFFF_FF80);
        send_req({$urandom, $urandom}, 48'h1234_5678_9ABC, 32'd3);
        send_req({$urandom, $urandom}, 48'hFEDC_BA98_7654, 32'd0);

        set_geometry(32'd1000, 32'd7);
        send_req(64'd12, 48'd999, 32'd5002);
        send_req(64'hFFFF_FFFF_FFFF_FFFF, 48'd7000, 32'd1000);
        send_req(64'd0, OFF_TOP - 48'd1500, 32'd4000);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct = 34;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            wide = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: unit_field = UNIT_W'($urandom_range(1, 8));
                1: unit_field = UNIT_W'(1) << $urandom_range(0, 30);
                2: unit_field = UNIT_W'($urandom_range(1, 5000));
                3: unit_field = wide[UNIT_W-1:0];
                4: unit_field = ($urandom_range(0, 1) != 0) ? '0 : UNIT_MAX;
                default: unit_field = UNIT_W'($urandom_range(1, 70000));
            endcase
            case ($urandom_range(0, 7))
                0: drive_field = '0;
                1: drive_field = '1;
                2: drive_field = DRIVES_MAX;
                3: drive_field = DRV_CNT_W'($urandom);
                default: drive_field = DRV_CNT_W'($urandom_range(1, 64));
            endcase
            set_geometry({wide[63], unit_field}, {wide[56:32], drive_field});

            if (phase == PRESSURE_PHASE)
                hold_off_len = HOLD_OFF_CYCLES;

            repeat (ITEMS_PER_PHASE) begin
                hash = {$urandom, $urandom};
                if ($urandom_range(0, 7) == 0)
                    hash = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 70));
                wide     = {$urandom, $urandom};
                offset   = wide[47:0];
                span_len = 64'($urandom);
                case ($urandom_range(0, 9))
                    0: span_len = '0;
                    1: ;
                    2: begin
                        span     = unit_now * 3;
                        offset   = OFF_TOP - 48'({$urandom, $urandom} % span);
                        span_len = 1 + ({$urandom, $urandom} % (span * 2));
                    end
                    default: begin
                        if ($urandom_range(0, 1) != 0)
                            offset = offset - 48'(offset % unit_now);
                        span     = unit_now * $urandom_range(1, 66);
                        span_len = ($urandom_range(0, 3) == 0) ? span :
                                   1 + ({$urandom, $urandom} % span);
                    end
                endcase
                send_req(hash, offset, (span_len > 64'hFFFF_FFFF) ? '1 : span_len[31:0]);
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_total == 0 && pending == 0) begin
            $display("** stripe_read_segment_planner: PASSED **");
        end else begin
            $display("** stripe_read_segment_planner: FAILED **");
        end
        $finish;
    end

endmodule
